// File: hdl/mmnb_pkg.sv
package mmnb_pkg;

  // Default width of one sample, signed fixed point.
  localparam int unsigned SampleBitsDef = 32;

  localparam int unsigned LevelBits = 8;
  localparam logic [LevelBits-1:0] LevelMax = 8'd255;
  localparam logic [LevelBits-1:0] LevelMin = 8'd0;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [0:0] {
    OP_MEASURE = 1'b0,
    OP_CONVERT = 1'b1
  } op_e;

  // How the back end produces the level of one convert item.
  typedef enum logic [1:0] {
    CLS_DIVIDE = 2'd0,
    CLS_LOW    = 2'd1,
    CLS_HIGH   = 2'd2
  } cls_e;

  typedef struct packed {
    cls_e cls;
    logic clipped;
  } kind_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_DIV  = 1'b1
  } back_state_e;

endpackage

// File: hdl/mmnb_in_if.sv
interface mmnb_in_if
  import mmnb_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
);
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic                   first_of_image;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, operation, first_of_image, sample, input ready);
  modport sink   (input valid, operation, first_of_image, sample, output ready);
endinterface

// File: hdl/mmnb_out_if.sv
interface mmnb_out_if
  import mmnb_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [LevelBits-1:0] level;
  logic                 clipped;

  modport source (output valid, level, clipped, input ready);
  modport sink   (input valid, level, clipped, output ready);
endinterface

// File: hdl/mmnb_front.sv
module mmnb_front
  import mmnb_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef,
  parameter int unsigned ENTRY_BITS  = $bits(kind_t) + 2 * SAMPLE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mmnb_in_if.sink               in_i,
  input  logic                  full_i,
  output logic                  push_o,
  output logic [ENTRY_BITS-1:0] entry_o
);

  logic signed [SAMPLE_BITS-1:0] min_q, max_q;
  logic                          range_seen_q;
  logic signed [SAMPLE_BITS-1:0] sample_s;
  logic        [SAMPLE_BITS:0]   num_w, den_w;
  logic                          accept;
  kind_t                         kind;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign sample_s   = $signed(in_i.sample);
  assign push_o     = accept && (op_e'(in_i.operation) == OP_CONVERT);

  // Both differences are non-negative whenever the sample lies in range.
  assign num_w = {sample_s[SAMPLE_BITS-1], sample_s} - {min_q[SAMPLE_BITS-1], min_q};
  assign den_w = {max_q[SAMPLE_BITS-1], max_q} - {min_q[SAMPLE_BITS-1], min_q};

  always_comb begin
    if (max_q <= min_q) begin
      kind.cls     = CLS_LOW;
      kind.clipped = (sample_s != min_q);
    end else if (sample_s < min_q) begin
      kind.cls     = CLS_LOW;
      kind.clipped = 1'b1;
    end else if (sample_s > max_q) begin
      kind.cls     = CLS_HIGH;
      kind.clipped = 1'b1;
    end else begin
      kind.cls     = CLS_DIVIDE;
      kind.clipped = 1'b0;
    end
  end

  assign entry_o = {kind, num_w[SAMPLE_BITS-1:0], den_w[SAMPLE_BITS-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q        <= '0;
      max_q        <= '0;
      range_seen_q <= 1'b0;
    end else if (accept && (op_e'(in_i.operation) == OP_MEASURE)) begin
      range_seen_q <= 1'b1;
      if (in_i.first_of_image || !range_seen_q) begin
        min_q <= sample_s;
        max_q <= sample_s;
      end else begin
        if (sample_s < min_q) min_q <= sample_s;
        if (sample_s > max_q) max_q <= sample_s;
      end
    end
  end

endmodule

// File: hdl/mmnb_queue.sv
module mmnb_queue
  import mmnb_pkg::*;
#(
  parameter int unsigned DATA_BITS = 8,
  parameter int unsigned DEPTH     = QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [DATA_BITS-1:0] data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output logic [DATA_BITS-1:0] data_o
);

  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] mem_q [DEPTH];
  logic [PtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]   cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CntBits'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: hdl/mmnb_back.sv
module mmnb_back
  import mmnb_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef,
  parameter int unsigned ENTRY_BITS  = $bits(kind_t) + 2 * SAMPLE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [ENTRY_BITS-1:0] entry_i,
  output logic                  pop_o,
  mmnb_out_if.source            out_o
);

  localparam int unsigned ProdBits = SAMPLE_BITS + LevelBits;
  localparam int unsigned CntBits  = $clog2(LevelBits);

  back_state_e state_q, state_d;

  kind_t                  kind;
  logic [SAMPLE_BITS-1:0] num, den;
  logic [ProdBits-1:0]    prod;

  logic [SAMPLE_BITS-1:0] den_q, rem_q, rem_d;
  logic [LevelBits-1:0]   low_q, quo_q, quo_d;
  logic [CntBits-1:0]     cnt_q;
  logic [SAMPLE_BITS:0]   trial, diff;
  logic                   qbit;

  logic                   out_valid_q;
  logic [LevelBits-1:0]   level_q;
  logic                   clipped_q;
  logic                   out_free;
  logic                   load_div, step_div, last_step, write_direct;

  assign {kind, num, den} = entry_i;

  // num * 255 as a shift and one subtract.
  assign prod = {num, {LevelBits{1'b0}}} - {{LevelBits{1'b0}}, num};

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  assign trial = {rem_q, low_q[LevelBits-1]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = !diff[SAMPLE_BITS];
  assign rem_d = qbit ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
  assign quo_d = {quo_q[LevelBits-2:0], qbit};

  assign out_free  = !out_valid_q || out_o.ready;
  assign last_step = (cnt_q == CntBits'(LevelBits - 1));

  always_comb begin
    state_d      = state_q;
    load_div     = 1'b0;
    step_div     = 1'b0;
    write_direct = 1'b0;
    pop_o        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          if (kind.cls == CLS_DIVIDE) begin
            load_div = 1'b1;
            pop_o    = 1'b1;
            state_d  = ST_DIV;
          end else if (out_free) begin
            write_direct = 1'b1;
            pop_o        = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (!last_step || out_free) begin
          step_div = 1'b1;
          if (last_step) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_div) begin
        cnt_q <= '0;
      end else if (step_div) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (write_direct || (step_div && last_step)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_div) begin
      den_q <= den;
      rem_q <= prod[ProdBits-1:LevelBits];
      low_q <= prod[LevelBits-1:0];
      quo_q <= '0;
    end else if (step_div) begin
      rem_q <= rem_d;
      low_q <= {low_q[LevelBits-2:0], 1'b0};
      quo_q <= quo_d;
    end
    if (write_direct) begin
      level_q   <= (kind.cls == CLS_HIGH) ? LevelMax : LevelMin;
      clipped_q <= kind.clipped;
    end else if (step_div && last_step) begin
      level_q   <= quo_d;
      clipped_q <= 1'b0;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.level   = level_q;
  assign out_o.clipped = clipped_q;

endmodule

// File: hdl/min_max_normalize_to_byte_top.sv
// Min-max contrast stretch to 8 bits. Send every sample of an image once as a
// measure item (operation 0, first_of_image set on the first one) and then
// again as convert items (operation 1); each convert item returns exactly one
// result, level = floor((sample - min) * 255 / (max - min)) saturated to
// 0..255, with clipped set when the sample lay outside the measured range.
// A zero range gives level 0. Measure items give no result. Samples are
// signed fixed point, SAMPLE_BITS wide. A convert item whose sample lies in
// the range, ends included, holds the back-end divider for one load and then
// one quotient bit per cycle, the last bit waiting while the output register
// is full; a clipped or zero-range convert item goes straight to that register
// once it is free. A two-item queue between the front and the back keeps
// accepting items while the divider works, so measure items flow at one per
// cycle as long as the queue has room; once two convert items wait in it, the
// input is held off for every item, measure items included, until the back
// takes one. The divider takes the next in-range item only once it is done.
module min_max_normalize_to_byte_top
  import mmnb_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mmnb_in_if.sink    in_i,
  mmnb_out_if.source out_o
);

  localparam int unsigned EntryBits = $bits(kind_t) + 2 * SAMPLE_BITS;

  // Front to queue: classified convert items with their range differences.
  logic                 push;
  logic                 full;
  logic [EntryBits-1:0] push_entry;

  // Queue to back.
  logic                 q_valid;
  logic                 pop;
  logic [EntryBits-1:0] q_entry;

  // The front tracks the running minimum and maximum and turns each convert
  // item into a class plus numerator and denominator of the division.
  mmnb_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .ENTRY_BITS (EntryBits)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .entry_o(push_entry)
  );

  mmnb_queue #(
    .DATA_BITS(EntryBits),
    .DEPTH    (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_entry),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (q_entry)
  );

  // The back runs the bit-serial divider and holds the result in an output
  // register, so a finished result may wait while the next item is taken.
  mmnb_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .ENTRY_BITS (EntryBits)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(q_valid),
    .entry_i(q_entry),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
